[rtl/atpr_pkg.sv]
// Shared constants, types and functions for the tilt pitch/roll core.
package atpr_pkg;

  localparam int CordicIters = 16;
  localparam int SqWidth     = 27;  // x^2, y^2, z^2 each <= 2^26
  localparam int QWidth      = 44;  // radicand, fits 2^44
  localparam int RootWidth   = 22;  // floor(sqrt(Q)) < 2^22
  localparam int VecWidth    = 26;  // CORDIC x/y datapath
  localparam int AngWidth    = 25;  // degrees in Q16
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = 2;
  localparam logic [15:0] MuReset = 16'd655;
  localparam logic signed [10:0] PitchLim = 11'sd900;
  localparam logic signed [11:0] RollLim  = 12'sd1800;

  // Classified item passed from front to back.
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [13:0] z;
    logic        [15:0] mu;
  } atpr_item_t;

  function automatic logic signed [AngWidth-1:0] atan_q16(input int i);
    logic signed [AngWidth-1:0] r;
    case (i)
      0: r = 25'sd2949120;  1: r = 25'sd1740967;  2: r = 25'sd919879;
      3: r = 25'sd466945;   4: r = 25'sd234379;   5: r = 25'sd117304;
      6: r = 25'sd58666;    7: r = 25'sd29335;    8: r = 25'sd14668;
      9: r = 25'sd7334;     10: r = 25'sd3667;    11: r = 25'sd1833;
      12: r = 25'sd917;     13: r = 25'sd458;     14: r = 25'sd229;
      15: r = 25'sd115;     16: r = 25'sd57;      17: r = 25'sd29;
      18: r = 25'sd14;      19: r = 25'sd7;       20: r = 25'sd4;
      21: r = 25'sd2;       22: r = 25'sd1;       default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/accel_tilt_pitch_roll_core.sv]
// Top level: accelerometer pitch and roll via square root and CORDIC.
// Pipeline: an input transaction is written into the queue, then passes squares,
//   radicand, 22 square-root bit stages, fold, 16 CORDIC stages and scale,
//   and is loaded into the saturated result register.
// Throughput: one transaction per cycle; a 4-entry queue decouples front
//   and back, and the back pipeline stalls as a whole on m_axis_tready.
// Reset: rst (synchronous, active high) clears valids and queue pointers
//   and loads roll_mu_q16 with 655.
module accel_tilt_pitch_roll_core import atpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // roll_mu_q16
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // x_word[15:0], y_word[31:16], z_word[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // pitch_tenths[10:0], roll_tenths[22:11], 0
);

  atpr_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;
  logic signed [10:0] pitch;
  logic signed [11:0] roll;

  // Front: take the transaction and classify it into signed samples.
  atpr_front u_front (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  // Queue: hold items while the back end stalls.
  atpr_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  // Back: compute the two angles.
  atpr_back u_back (
    .clk, .rst,
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .pitch, .roll
  );

  assign m_axis_tdata = {1'b0, roll, pitch};

endmodule

[rtl/atpr_front.sv]
// Front end: accept an axis transaction, drop the low bits, latch mu.
module atpr_front import atpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_data,
  output logic        item_valid,
  input  logic        item_ready,
  output atpr_item_t  item
);

  logic [15:0] mu;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= MuReset;
    end else if (cfg_we) begin
      mu <= cfg_wdata;
    end
  end

  assign in_ready   = item_ready;
  assign item_valid = in_valid;

  always_comb begin
    item.x  = in_data[15:2];
    item.y  = in_data[31:18];
    item.z  = in_data[47:34];
    item.mu = mu;
  end

endmodule

[rtl/atpr_queue.sv]
// Short FIFO between the front end and the angle pipeline.
module atpr_queue import atpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  atpr_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output atpr_item_t rd_item
);

  atpr_item_t mem [QueueDepth];
  logic [QueueAw-1:0] wp, rp;
  logic [QueueAw:0]   cnt;
  logic wr_fire, rd_fire;

  assign wr_ready = (cnt != (QueueAw+1)'(QueueDepth));
  assign rd_valid = (cnt != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_fire) wp <= wp + 1'b1;
      if (rd_fire) rp <= rp + 1'b1;
      cnt <= cnt + (QueueAw+1)'(wr_fire) - (QueueAw+1)'(rd_fire);
    end
  end

endmodule

[rtl/atpr_back.sv]
// Back end: squares, pipelined square roots, pipelined CORDIC, scaling.
module atpr_back import atpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  atpr_item_t        item,
  output logic              res_valid,
  input  logic              res_ready,
  output logic signed [10:0] pitch,
  output logic signed [11:0] roll
);

  localparam int SqrtSteps = RootWidth;
  localparam int NStages   = 1 + 1 + SqrtSteps + 1 + CordicIters + 2;

  typedef struct packed {
    logic signed [VecWidth-1:0] d;
    logic signed [VecWidth-1:0] n;
    logic signed [AngWidth-1:0] a;
    logic                       spec;
  } cord_t;

  logic advance;
  logic [NStages-1:0] vld;

  assign advance    = !res_valid || res_ready;
  assign item_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NStages-2:0], item_valid};
    end
  end
  assign res_valid = vld[NStages-1];

  // Stage 0: squares.
  logic signed [13:0] s0_x, s0_y, s0_z;
  logic [SqWidth-1:0] s0_y2, s0_z2, s0_x2;
  logic [15:0] s0_mu;
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_x  <= item.x;
      s0_y  <= item.y;
      s0_z  <= item.z;
      s0_mu <= item.mu;
      s0_x2 <= SqWidth'(item.x * item.x);
      s0_y2 <= SqWidth'(item.y * item.y);
      s0_z2 <= SqWidth'(item.z * item.z);
    end
  end

  // Stage 1: radicands.
  logic [QWidth-1:0] s1_qp, s1_qr;
  logic signed [13:0] s1_x, s1_y;
  logic s1_zle;
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_qp  <= {(SqWidth+1)'(s0_y2) + (SqWidth+1)'(s0_z2), 16'd0};
      s1_qr  <= QWidth'(s0_mu * s0_x2) + {QWidth'(s0_z2) << 16};
      s1_x   <= s0_x;
      s1_y   <= s0_y;
      s1_zle <= (s0_z <= 14'sd0);
    end
  end

  // Restoring square root, one result bit per stage, two roots in lockstep.
  logic [QWidth-1:0]    rq_p [SqrtSteps+1];
  logic [QWidth-1:0]    rq_r [SqrtSteps+1];
  logic [RootWidth-1:0] rr_p [SqrtSteps+1];
  logic [RootWidth-1:0] rr_r [SqrtSteps+1];
  logic signed [13:0]   sq_x [SqrtSteps+1];
  logic signed [13:0]   sq_y [SqrtSteps+1];
  logic                 sq_z [SqrtSteps+1];

  always_comb begin
    rq_p[0] = s1_qp;
    rq_r[0] = s1_qr;
    rr_p[0] = '0;
    rr_r[0] = '0;
    sq_x[0] = s1_x;
    sq_y[0] = s1_y;
    sq_z[0] = s1_zle;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int B = SqrtSteps - 1 - k;
    logic [QWidth-1:0] tp, tr;
    always_comb begin
      tp = (QWidth'(rr_p[k]) << (B+1) | (QWidth'(1) << (2*B)));
      tr = (QWidth'(rr_r[k]) << (B+1) | (QWidth'(1) << (2*B)));
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        if (rq_p[k] >= tp) begin
          rq_p[k+1] <= rq_p[k] - tp;
          rr_p[k+1] <= rr_p[k] | (RootWidth'(1) << B);
        end else begin
          rq_p[k+1] <= rq_p[k];
          rr_p[k+1] <= rr_p[k];
        end
        if (rq_r[k] >= tr) begin
          rq_r[k+1] <= rq_r[k] - tr;
          rr_r[k+1] <= rr_r[k] | (RootWidth'(1) << B);
        end else begin
          rq_r[k+1] <= rq_r[k];
          rr_r[k+1] <= rr_r[k];
        end
        sq_x[k+1] <= sq_x[k];
        sq_y[k+1] <= sq_y[k];
        sq_z[k+1] <= sq_z[k];
      end
    end
  end

  // Pre-rotation stage: set up numerator/denominator, quadrant fold.
  cord_t cp [CordicIters+1];
  cord_t cr [CordicIters+1];

  function automatic cord_t prerot(input logic signed [VecWidth-1:0] n,
                                   input logic signed [VecWidth-1:0] d);
    cord_t c;
    c.spec = (n == '0) && (d == '0);
    c.a = '0;
    c.d = d;
    c.n = n;
    if (d < 0) begin
      if (n >= 0) begin
        c.a = AngWidth'(90 * 65536);
        c.d = n;
        c.n = -d;
      end else begin
        c.a = -AngWidth'(90 * 65536);
        c.d = -n;
        c.n = d;
      end
    end
    return c;
  endfunction

  logic signed [VecWidth-1:0] pn, pd, rn, rd;
  always_comb begin
    pn = -(VecWidth'(sq_x[SqrtSteps]) <<< 8);
    pd = VecWidth'({1'b0, rr_p[SqrtSteps]});
    rn = VecWidth'(sq_y[SqrtSteps]) <<< 8;
    rd = sq_z[SqrtSteps] ? -VecWidth'({1'b0, rr_r[SqrtSteps]})
                         :  VecWidth'({1'b0, rr_r[SqrtSteps]});
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      cp[0] <= prerot(pn, pd);
      cr[0] <= prerot(rn, rd);
    end
  end

  // CORDIC vectoring, one micro-rotation per stage.
  for (genvar i = 0; i < CordicIters; i++) begin : g_cord
    always_ff @(posedge clk) begin
      if (advance) begin
        cp[i+1].spec <= cp[i].spec;
        cr[i+1].spec <= cr[i].spec;
        if (!cp[i].n[VecWidth-1]) begin
          cp[i+1].d <= cp[i].d + (cp[i].n >>> i);
          cp[i+1].n <= cp[i].n - (cp[i].d >>> i);
          cp[i+1].a <= cp[i].a + atan_q16(i);
        end else begin
          cp[i+1].d <= cp[i].d - (cp[i].n >>> i);
          cp[i+1].n <= cp[i].n + (cp[i].d >>> i);
          cp[i+1].a <= cp[i].a - atan_q16(i);
        end
        if (!cr[i].n[VecWidth-1]) begin
          cr[i+1].d <= cr[i].d + (cr[i].n >>> i);
          cr[i+1].n <= cr[i].n - (cr[i].d >>> i);
          cr[i+1].a <= cr[i].a + atan_q16(i);
        end else begin
          cr[i+1].d <= cr[i].d - (cr[i].n >>> i);
          cr[i+1].n <= cr[i].n + (cr[i].d >>> i);
          cr[i+1].a <= cr[i].a - atan_q16(i);
        end
      end
    end
  end

  // Scale by ten.
  logic signed [AngWidth+3:0] tp10, tr10;
  logic sp10, sr10;
  always_ff @(posedge clk) begin
    if (advance) begin
      tp10 <= (AngWidth+4)'(cp[CordicIters].a) * (AngWidth+4)'(10);
      tr10 <= (AngWidth+4)'(cr[CordicIters].a) * (AngWidth+4)'(10);
      sp10 <= cp[CordicIters].spec;
      sr10 <= cr[CordicIters].spec;
    end
  end

  // Truncate toward zero, saturate, apply the zero-vector cases.
  function automatic logic signed [12:0] trunc16(input logic signed [AngWidth+3:0] t);
    logic [AngWidth+3:0] m;
    logic signed [12:0]  r;
    m = t[AngWidth+3] ? -t : t;
    r = 13'(m >> 16);
    return t[AngWidth+3] ? -r : r;
  endfunction

  logic signed [12:0] pt, rt;
  always_comb begin
    pt = trunc16(tp10);
    rt = trunc16(tr10);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sp10) pitch <= '0;
      else if (pt > 13'(PitchLim)) pitch <= PitchLim;
      else if (pt < -13'(PitchLim)) pitch <= -PitchLim;
      else pitch <= 11'(pt);
      if (sr10) roll <= RollLim;
      else if (rt > 13'(RollLim)) roll <= RollLim;
      else if (rt < -13'(RollLim)) roll <= -RollLim;
      else roll <= 12'(rt);
    end
  end

endmodule
